// ===== rtl/core/snt_pkg.sv =====
// ---------------------------------------------------------------------------
// snt_pkg
// Shared types, codes and key compare functions for the sorted neighbor table.
// ---------------------------------------------------------------------------
package snt_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int POS_W           = 4;
    localparam int COUNT_OUT_W     = 5;
    localparam logic [15:0] INVALID_ID = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_UPDATE = 3'd1,
        OP_REMOVE = 3'd2,
        OP_GET    = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0]        id;
        logic [7:0]         dtype;
        logic [7:0]         ver;
        logic [7:0]         hops;
        logic signed [7:0]  sig;
    } nb_entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_CLEAR  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t mode;
        logic     tie_en;
    } cell_ctrl_t;

    // a strictly ahead of b
    function automatic logic goes_before(input nb_entry_t a, input nb_entry_t b);
        logic r;
        if (a.hops != b.hops)
        begin
            r = (a.hops < b.hops);
        end
        else
        begin
            r = ($signed(a.sig) > $signed(b.sig));
        end
        return r;
    endfunction

    function automatic logic keys_equal(input nb_entry_t a, input nb_entry_t b);
        return (a.hops == b.hops) && (a.sig == b.sig);
    endfunction

endpackage

// ===== rtl/core/snt_if.sv =====
// ---------------------------------------------------------------------------
// snt_req_if / snt_rsp_if
// Valid/ready channels for table operations and their results.
// ---------------------------------------------------------------------------
interface snt_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic [3:0]        position;
    logic [15:0]       node_id;
    logic [7:0]        node_kind;
    logic [7:0]        version;
    logic [7:0]        hop_count;
    logic signed [7:0] signal_strength;

    modport source (
        output valid, operation, position, node_id, node_kind, version,
               hop_count, signal_strength,
        input  ready
    );
    modport sink (
        input  valid, operation, position, node_id, node_kind, version,
               hop_count, signal_strength,
        output ready
    );
endinterface

interface snt_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [4:0]        entry_count;
    logic [15:0]       out_node_id;
    logic [7:0]        out_node_kind;
    logic [7:0]        out_version;
    logic [7:0]        out_hop_count;
    logic signed [7:0] out_signal_strength;

    modport source (
        output valid, status, entry_count, out_node_id, out_node_kind,
               out_version, out_hop_count, out_signal_strength,
        input  ready
    );
    modport sink (
        input  valid, status, entry_count, out_node_id, out_node_kind,
               out_version, out_hop_count, out_signal_strength,
        output ready
    );
endinterface

// ===== rtl/core/snt_cell.sv =====
// ---------------------------------------------------------------------------
// snt_cell
// One table slot: holds an entry, decides insert/shift against its neighbors.
// ---------------------------------------------------------------------------
module snt_cell import snt_pkg::*; #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] count_lim,
    input  logic [CNT_W-1:0] pos_ext,
    input  nb_entry_t        new_entry,
    input  nb_entry_t        left_entry,
    input  logic             left_ins,
    input  nb_entry_t        right_entry,
    output logic             ins,
    output nb_entry_t        entry
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    nb_entry_t entry_reg;
    nb_entry_t entry_next;
    logic      held;

    assign held = (MY_IDX < count_lim);

    // insertion point flag, monotone along the row
    assign ins = !held || goes_before(new_entry, entry_reg) ||
                 (ctrl.tie_en && keys_equal(new_entry, entry_reg) && (MY_IDX >= pos_ext));

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.mode)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_INSERT:
            begin
                if (left_ins)
                begin
                    entry_next = left_entry;
                end
                else if (ins)
                begin
                    entry_next = new_entry;
                end
            end
            CELL_REMOVE:
            begin
                if (MY_IDX >= pos_ext)
                begin
                    entry_next = right_entry;
                end
            end
            CELL_CLEAR:
            begin
                entry_next.id = INVALID_ID;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/sorted_neighbor_table_core.sv =====
// ---------------------------------------------------------------------------
// sorted_neighbor_table_core
// Neighbor table kept sorted by hop count, then signal strength, in a cell row.
// ---------------------------------------------------------------------------
// Add, remove, get and clear act on the row when taken; update first closes the
// gap at the old position, then in state S_UPD inserts the new entry. The row
// shifts by at most one slot per cycle. Results are registered, so a new
// transaction is taken while the previous result is being drained. No clearing
// pass after reset; only held slots are ever read.
module sorted_neighbor_table_core import snt_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    snt_req_if.sink   req,
    snt_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    nb_entry_t        upd_entry_reg, upd_entry_next;

    logic             rsp_valid_reg, rsp_valid_next;
    status_t          status_reg, status_next;
    logic [CNT_W-1:0] rsp_count_reg, rsp_count_next;
    nb_entry_t        rd_reg, rd_next;

    logic             fire;
    logic             pos_ok;
    nb_entry_t        in_entry;
    nb_entry_t        new_entry;
    cell_ctrl_t       ctrl;
    logic [CNT_W-1:0] count_lim;
    logic [CNT_W-1:0] pos_ext;

    nb_entry_t cell_q      [MAX_ENTRIES];
    nb_entry_t left_q      [MAX_ENTRIES];
    nb_entry_t right_q     [MAX_ENTRIES];
    logic      cell_ins    [MAX_ENTRIES];
    logic      left_ins    [MAX_ENTRIES];

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign fire      = req.valid && req.ready;
    assign pos_ok    = CMP_W'(req.position) < CMP_W'(count_reg);

    assign in_entry.id    = req.node_id;
    assign in_entry.dtype = req.node_kind;
    assign in_entry.ver   = req.version;
    assign in_entry.hops  = req.hop_count;
    assign in_entry.sig   = req.signal_strength;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        upd_entry_next = upd_entry_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        rsp_count_next = rsp_count_reg;
        rd_next        = rd_reg;
        ctrl.mode      = CELL_HOLD;
        ctrl.tie_en    = 1'b0;
        count_lim      = count_reg;
        pos_ext        = CNT_W'(req.position);
        new_entry      = in_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    rd_next        = '0;
                    unique case (op_t'(req.operation))
                        OP_ADD:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.mode  = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ctrl.mode      = CELL_REMOVE;
                                pos_next       = CNT_W'(req.position);
                                upd_entry_next = in_entry;
                                rsp_valid_next = 1'b0;
                                state_next     = S_UPD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ctrl.mode  = CELL_REMOVE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_GET:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                rd_next = cell_q[IDX_W'(req.position)];
                            end
                        end
                        OP_CLEAR:
                        begin
                            ctrl.mode  = CELL_CLEAR;
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                    rsp_count_next = count_next;
                end
            end
            S_UPD:
            begin
                // insert behind equal keys ahead of the old slot, ahead of the rest
                ctrl.mode      = CELL_INSERT;
                ctrl.tie_en    = 1'b1;
                count_lim      = count_reg - CNT_W'(1);
                pos_ext        = pos_reg;
                new_entry      = upd_entry_reg;
                rsp_valid_next = 1'b1;
                status_next    = ST_OK;
                rsp_count_next = count_reg;
                rd_next        = '0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        upd_entry_reg <= upd_entry_next;
        status_reg    <= status_next;
        rsp_count_reg <= rsp_count_next;
        rd_reg        <= rd_next;
    end

    genvar i;
    generate
        for (i = 0; i < MAX_ENTRIES; i++)
        begin : g_row
            if (i == 0)
            begin : g_first
                assign left_q[i]   = cell_q[i];
                assign left_ins[i] = 1'b0;
            end
            else
            begin : g_mid
                assign left_q[i]   = cell_q[i-1];
                assign left_ins[i] = cell_ins[i-1];
            end
            if (i == MAX_ENTRIES - 1)
            begin : g_last
                assign right_q[i] = cell_q[i];
            end
            else
            begin : g_inner
                assign right_q[i] = cell_q[i+1];
            end

            snt_cell #(
                .CNT_W (CNT_W),
                .INDEX (i)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count_lim   (count_lim),
                .pos_ext     (pos_ext),
                .new_entry   (new_entry),
                .left_entry  (left_q[i]),
                .left_ins    (left_ins[i]),
                .right_entry (right_q[i]),
                .ins         (cell_ins[i]),
                .entry       (cell_q[i])
            );
        end
    endgenerate

    assign rsp.valid               = rsp_valid_reg;
    assign rsp.status              = status_reg;
    assign rsp.entry_count         = COUNT_OUT_W'(rsp_count_reg);
    assign rsp.out_node_id         = rd_reg.id;
    assign rsp.out_node_kind       = rd_reg.dtype;
    assign rsp.out_version         = rd_reg.ver;
    assign rsp.out_hop_count       = rd_reg.hops;
    assign rsp.out_signal_strength = rd_reg.sig;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count beyond table size");

    a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |=> rsp_valid_reg && state_reg == S_IDLE)
        else $error("update did not complete in its second cycle");

    a_upd_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> !req.ready)
        else $error("transaction accepted during update insert");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.operation == OP_ADD && count_reg != FULL_CNT
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("add did not grow the table");
`endif

endmodule
